// ===== design/pdrj_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrj_pkg: shared types and constants of the packet impairment block
// Action codes, register indexes, widths and the request and response
// bundles of the shared remainder unit.
// ----------------------------------------------------------------------------
package pdrj_pkg;

  localparam int unsigned RngW   = 32;
  localparam int unsigned PctW   = 7;
  localparam int unsigned FieldW = 16;
  localparam int unsigned DivW   = FieldW + 1;
  localparam int unsigned CntW   = $clog2(RngW);
  localparam int unsigned IdxW   = 2;

  localparam logic [PctW-1:0] PctFull = PctW'(100);
  localparam logic [RngW-1:0] SeedOne = RngW'(1);

  typedef enum logic [1:0] {
    ACT_SEND = 2'd0,
    ACT_DROP = 2'd1,
    ACT_HOLD = 2'd2
  } action_e;

  typedef enum logic [IdxW-1:0] {
    REG_DROP    = 2'd0,
    REG_REORDER = 2'd1,
    REG_JITTER  = 2'd2,
    REG_SEED    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic            start;
    logic [RngW-1:0] dividend;
    logic [DivW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [DivW-1:0] rem;
  } mod_rsp_t;

endpackage

// ===== design/pdrj_rng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrj_rng: 32-bit xorshift generator
// Advances one draw per step and reloads from the seed on a load request.
// ----------------------------------------------------------------------------
module pdrj_rng import pdrj_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic [RngW-1:0] seed_i,
  input  logic            step_i,
  output logic [RngW-1:0] next_o
);

  logic [RngW-1:0] state_q;
  logic [RngW-1:0] s1;
  logic [RngW-1:0] s2;
  logic [RngW-1:0] s3;

  always_comb begin
    s1 = state_q ^ (state_q << 13);
    s2 = s1 ^ (s1 >> 17);
    s3 = s2 ^ (s2 << 5);
    next_o = (s3 == '0) ? SeedOne : s3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeedOne;
    end else if (load_i) begin
      state_q <= seed_i;
    end else if (step_i) begin
      state_q <= next_o;
    end
  end

endmodule

// ===== design/pdrj_mod.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrj_mod: iterative remainder unit
// Restoring division of a 32-bit draw by a 17-bit divisor, one dividend bit
// per cycle; the remainder is valid with the done pulse.
// ----------------------------------------------------------------------------
module pdrj_mod import pdrj_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [RngW-1:0] dvd_q;
  logic [DivW-1:0] dvs_q;
  logic [DivW-1:0] rem_q;
  logic [DivW:0]   trial;
  logic [DivW-1:0] rem_d;

  always_comb begin
    trial = {rem_q, dvd_q[RngW-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = DivW'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[DivW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[RngW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ===== design/packet_drop_reorder_jitter_impairer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_drop_reorder_jitter_impairer: per-packet send, drop or hold decision
// A sequencer draws from a xorshift generator and reduces each draw through
// one shared iterative remainder unit for the reorder, drop and jitter rolls.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake             Beat
//   in       input      in_valid_i/in_stall_o packet_id, packet_length
//   out      output     out_valid_o/out_stall_i action, id, length, delay, last
//   cfg      input      cfg_valid_i/cfg_ready_o register index and data
//
// The rolls run one after another in the shared remainder unit, which sets the rate.
// With impairment off a packet goes straight to its result beat; with it on it
// takes up to three rolls (reorder, drop, jitter). Releasing a held packet gives
// two result beats, each with its own rolls, and either beat may be stalled.
// Input is stalled from acceptance until the last result beat is taken.
// Reset leaves the generator at one, nothing held and all settings off.
// ----------------------------------------------------------------------------
module packet_drop_reorder_jitter_impairer import pdrj_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FieldW-1:0] packet_id_i,
  input  logic [FieldW-1:0] packet_length_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        action_o,
  output logic [FieldW-1:0] out_packet_id_o,
  output logic [FieldW-1:0] out_length_o,
  output logic [FieldW-1:0] delay_ms_o,
  output logic              last_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [IdxW-1:0]   cfg_index_i,
  input  logic [RngW-1:0]   cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REO_GO,
    S_REO_WAIT,
    S_DECIDE,
    S_DROP_WAIT,
    S_JIT_GO,
    S_JIT_WAIT,
    S_OUT
  } state_e;

  state_e            state_q;
  logic [PctW-1:0]   drop_q;
  logic [PctW-1:0]   reo_q;
  logic [FieldW-1:0] jit_q;
  logic [RngW-1:0]   seed_q;
  logic              held_valid_q;
  logic [FieldW-1:0] held_id_q;
  logic [FieldW-1:0] held_len_q;
  logic [FieldW-1:0] in_id_q;
  logic [FieldW-1:0] in_len_q;
  logic              two_q;
  logic              phase_q;
  logic              out_valid_q;
  action_e           act_q;
  logic [FieldW-1:0] out_id_q;
  logic [FieldW-1:0] out_len_q;
  logic [FieldW-1:0] delay_q;
  logic              last_q;

  logic              cfg_we;
  logic [PctW-1:0]   pct_sat;
  logic [RngW-1:0]   seed_d;
  logic              in_accept;
  logic              imp_off;
  logic [FieldW-1:0] cur_id;
  logic [FieldW-1:0] cur_len;
  logic              cur_last;
  logic              use_pct;
  logic [RngW-1:0]   rng_next;
  mod_req_t          mod_req;
  mod_rsp_t          mod_rsp;

  assign cfg_ready_o = (state_q == S_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign pct_sat     = (cfg_data_i[PctW-1:0] > PctFull) ? PctFull : cfg_data_i[PctW-1:0];
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign imp_off     = (drop_q == '0) && (reo_q == '0) && (jit_q == '0);
  assign cur_id      = phase_q ? held_id_q : in_id_q;
  assign cur_len     = phase_q ? held_len_q : in_len_q;
  assign cur_last    = !(two_q && !phase_q);

  always_comb begin
    if (cfg_index_i == REG_SEED) begin
      seed_d = (cfg_data_i == '0) ? SeedOne : cfg_data_i;
    end else begin
      seed_d = seed_q;
    end
  end

  always_comb begin
    use_pct = (state_q == S_REO_GO) || ((state_q == S_DECIDE) && (drop_q != '0));
    mod_req.start = (state_q == S_REO_GO) || (state_q == S_JIT_GO) ||
                    ((state_q == S_DECIDE) && ((drop_q != '0) || (jit_q != '0)));
    mod_req.dividend = rng_next;
    mod_req.divisor  = use_pct ? DivW'(PctFull) : ({1'b0, jit_q} + DivW'(1));
  end

  pdrj_rng u_rng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (cfg_we),
    .seed_i (seed_d),
    .step_i (mod_req.start),
    .next_o (rng_next)
  );

  pdrj_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      drop_q       <= '0;
      reo_q        <= '0;
      jit_q        <= '0;
      seed_q       <= SeedOne;
      held_valid_q <= 1'b0;
      two_q        <= 1'b0;
      phase_q      <= 1'b0;
      out_valid_q  <= 1'b0;
      act_q        <= ACT_SEND;
      last_q       <= 1'b0;
    end else begin
      if (cfg_we) begin
        held_valid_q <= 1'b0;
        seed_q       <= seed_d;
        unique case (cfg_index_i)
          REG_DROP:    drop_q <= pct_sat;
          REG_REORDER: reo_q  <= pct_sat;
          REG_JITTER:  jit_q  <= cfg_data_i[FieldW-1:0];
          REG_SEED:    ;
          default:     ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            in_id_q  <= packet_id_i;
            in_len_q <= packet_length_i;
            phase_q  <= 1'b0;
            two_q    <= held_valid_q && !imp_off;
            if (imp_off) begin
              act_q       <= ACT_SEND;
              out_id_q    <= packet_id_i;
              out_len_q   <= packet_length_i;
              delay_q     <= '0;
              last_q      <= 1'b1;
              out_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end else if (held_valid_q) begin
              state_q <= S_DECIDE;
            end else if ((packet_length_i != '0) && (reo_q != '0)) begin
              state_q <= S_REO_GO;
            end else begin
              state_q <= S_DECIDE;
            end
          end
        end
        S_REO_GO: begin
          state_q <= S_REO_WAIT;
        end
        S_REO_WAIT: begin
          if (mod_rsp.done) begin
            if (mod_rsp.rem < DivW'(reo_q)) begin
              held_valid_q <= 1'b1;
              held_id_q    <= in_id_q;
              held_len_q   <= in_len_q;
              act_q        <= ACT_HOLD;
              out_id_q     <= in_id_q;
              out_len_q    <= in_len_q;
              delay_q      <= '0;
              last_q       <= 1'b1;
              out_valid_q  <= 1'b1;
              state_q      <= S_OUT;
            end else begin
              state_q <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          out_id_q  <= cur_id;
          out_len_q <= cur_len;
          last_q    <= cur_last;
          if (drop_q != '0) begin
            state_q <= S_DROP_WAIT;
          end else if (jit_q != '0) begin
            state_q <= S_JIT_WAIT;
          end else begin
            act_q       <= ACT_SEND;
            delay_q     <= '0;
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_DROP_WAIT: begin
          if (mod_rsp.done) begin
            if (mod_rsp.rem < DivW'(drop_q)) begin
              act_q       <= ACT_DROP;
              delay_q     <= '0;
              out_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end else if (jit_q != '0) begin
              state_q <= S_JIT_GO;
            end else begin
              act_q       <= ACT_SEND;
              delay_q     <= '0;
              out_valid_q <= 1'b1;
              state_q     <= S_OUT;
            end
          end
        end
        S_JIT_GO: begin
          state_q <= S_JIT_WAIT;
        end
        S_JIT_WAIT: begin
          if (mod_rsp.done) begin
            act_q       <= ACT_SEND;
            delay_q     <= mod_rsp.rem[FieldW-1:0];
            out_valid_q <= 1'b1;
            state_q     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (two_q && !phase_q) begin
              phase_q      <= 1'b1;
              held_valid_q <= 1'b0;
              state_q      <= S_DECIDE;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign action_o        = act_q;
  assign out_packet_id_o = out_id_q;
  assign out_length_o    = out_len_q;
  assign delay_ms_o      = delay_q;
  assign last_o          = last_q;

endmodule

// ===== design/pdrj_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdrj_chk: port-level checks of the packet impairment block
// Watches the result and input channels and is bound to the top level.
// ----------------------------------------------------------------------------
module pdrj_chk import pdrj_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        action_o,
  input logic [FieldW-1:0] out_packet_id_o,
  input logic [FieldW-1:0] delay_ms_o,
  input logic              last_o
);

  // A hold beat always closes its packet and never carries a delay.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == ACT_HOLD)) |-> ((delay_ms_o == '0) && last_o))
    else $error("hold beat with delay or without last");

  // A dropped packet carries no delay.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == ACT_DROP)) |-> (delay_ms_o == '0))
    else $error("drop beat with nonzero delay");

  // The input stays stalled while a result beat is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  // An accepted packet stalls the input on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_packet_id_o)))
    else $error("stalled result beat changed");

endmodule

bind packet_drop_reorder_jitter_impairer pdrj_chk u_pdrj_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .action_o        (action_o),
  .out_packet_id_o (out_packet_id_o),
  .delay_ms_o      (delay_ms_o),
  .last_o          (last_o)
);
